// File: hw/rtl/tlvsp_pkg.sv
// Shared types and constants for the TLV stream parser.
// Beat payload structs, register indexes, result kind and status codes.
// No dependencies.
`timescale 1ns / 1ps

package tlvsp_pkg;

    // Width of the per-message record counters (they saturate at the top).
    localparam int COUNT_BITS = 8;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_HEADER_SKIP    = 2'd0;
    localparam logic [1:0] REG_ENCRYPTED_TYPE = 2'd1;
    localparam logic [1:0] REG_MAX_RECORDS    = 2'd2;

    localparam logic [3:0]  HEADER_SKIP_RST    = 4'd5;
    localparam logic [15:0] ENCRYPTED_TYPE_RST = 16'd0;
    localparam logic [7:0]  MAX_RECORDS_RST    = 8'd255;

    // Result kinds.
    localparam logic [1:0] KIND_RECORD  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Summary status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_HDR_TRUNC = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  record_count;
        logic [7:0]  encrypted_count;
        logic [1:0]  status;
        logic        last;
    } out_beat_t;

endpackage

// File: hw/rtl/tlv_stream_parser.sv
// TLV stream parser top level: byte-serial record parser with a result queue.
// Depends on tlvsp_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_valid/s_ready/s_data carry one message byte per beat; end_of_message
//   flags the final byte. m_valid/m_ready/m_data carry result beats: a record
//   start when a record header completes, one beat per payload byte, and a
//   summary after the final byte. A byte causes zero, one or two results.
//   cfg_wr_en/cfg_index/cfg_wdata write header_skip (0), encrypted_type (1)
//   and max_records (2); write only while the parser is idle.
//   Latency: with the queue empty, a result is on m_data the cycle after its
//   byte is accepted; otherwise it waits behind the results ahead of it.
//   Throughput: one byte per cycle while s_ready is high. Results drain at
//   one per cycle while m_ready is high, from a four-entry queue; s_ready
//   drops when fewer than two entries are free, so a byte that causes two
//   results (payload plus summary) can hold off the bytes behind it.
//   Reset (aresetn low, synchronous) empties the queue, returns the parser
//   to the header-skip phase and loads the register reset values.
//   When the receiver stalls, the queue fills and s_ready falls; no result
//   is lost, and the head result holds steady until taken.
module tlv_stream_parser
    import tlvsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [2:0] {
        PH_SKIP, PH_THI, PH_TLO, PH_LHI, PH_LLO, PH_PAY, PH_IGN
    } phase_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    // configuration
    logic [3:0]  header_skip_reg;
    logic [15:0] encrypted_type_reg;
    logic [7:0]  max_records_reg;

    // per-message state
    phase_t                phase_reg, phase_next;
    logic [3:0]            skip_reg, skip_next;
    logic [15:0]           type_reg, type_next;
    logic [15:0]           len_reg, len_next;
    logic [15:0]           pos_reg, pos_next;
    logic [COUNT_BITS-1:0] records_reg, records_next;
    logic [COUNT_BITS-1:0] encrypted_reg, encrypted_next;

    // result queue
    out_beat_t          q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    logic       s_fire, m_fire;
    logic       r0_valid;
    out_beat_t  r0_beat, sum_beat;
    phase_t     ph;
    logic       consume;
    logic [1:0] n_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_skip_reg    <= HEADER_SKIP_RST;
            encrypted_type_reg <= ENCRYPTED_TYPE_RST;
            max_records_reg    <= MAX_RECORDS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEADER_SKIP:    header_skip_reg    <= cfg_wdata[3:0];
                REG_ENCRYPTED_TYPE: encrypted_type_reg <= cfg_wdata;
                REG_MAX_RECORDS:    max_records_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = q_reg[rd_ptr_reg];
    assign m_fire  = m_valid && m_ready;

    always_comb begin
        ph             = phase_reg;
        consume        = 1'b1;
        skip_next      = skip_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        records_next   = records_reg;
        encrypted_next = encrypted_reg;
        r0_valid       = 1'b0;
        r0_beat        = '0;
        sum_beat       = '0;

        if (phase_reg == PH_SKIP) begin
            if (skip_reg < header_skip_reg) begin
                skip_next = skip_reg + 4'd1;
                consume   = 1'b0;
            end else begin
                ph = PH_THI;
            end
        end
        phase_next = ph;

        if (consume) begin
            unique case (ph)
                PH_THI: begin
                    if (16'(records_reg) >= 16'(max_records_reg)) begin
                        phase_next = PH_IGN;
                    end else begin
                        type_next  = {s_data.data_byte, 8'h00};
                        phase_next = PH_TLO;
                    end
                end
                PH_TLO: begin
                    type_next  = {type_reg[15:8], s_data.data_byte};
                    phase_next = PH_LHI;
                end
                PH_LHI: begin
                    len_next   = {s_data.data_byte, 8'h00};
                    phase_next = PH_LLO;
                end
                PH_LLO: begin
                    len_next              = {len_reg[15:8], s_data.data_byte};
                    r0_valid              = 1'b1;
                    r0_beat.kind          = KIND_RECORD;
                    r0_beat.record_type   = type_reg;
                    r0_beat.record_length = len_next;
                    if (records_reg != COUNT_TOP) begin
                        records_next = records_reg + 1'b1;
                    end
                    if (type_reg == encrypted_type_reg && encrypted_reg != COUNT_TOP) begin
                        encrypted_next = encrypted_reg + 1'b1;
                    end
                    pos_next   = '0;
                    phase_next = (len_next == '0) ? PH_THI : PH_PAY;
                end
                PH_PAY: begin
                    r0_valid              = 1'b1;
                    r0_beat.kind          = KIND_PAYLOAD;
                    r0_beat.record_type   = type_reg;
                    r0_beat.record_length = len_reg;
                    r0_beat.payload_byte  = s_data.data_byte;
                    r0_beat.payload_index = pos_reg;
                    pos_next              = pos_reg + 16'd1;
                    if (pos_next >= len_reg) begin
                        phase_next = PH_THI;
                    end
                end
                default: phase_next = PH_IGN;
            endcase
        end
        r0_beat.last = !s_data.end_of_message;

        // summary reflects the state after this byte
        sum_beat.kind            = KIND_SUMMARY;
        sum_beat.record_count    = 8'(records_next);
        sum_beat.encrypted_count = 8'(encrypted_next);
        sum_beat.status          = STATUS_OK;
        sum_beat.last            = 1'b1;
        if (phase_next == PH_TLO || phase_next == PH_LHI || phase_next == PH_LLO) begin
            sum_beat.status          = STATUS_HDR_TRUNC;
            sum_beat.encrypted_count = '0;
        end else if (phase_next == PH_PAY) begin
            sum_beat.status = STATUS_OVERRUN;
        end

        if (s_data.end_of_message) begin
            phase_next     = PH_SKIP;
            skip_next      = '0;
            type_next      = '0;
            len_next       = '0;
            pos_next       = '0;
            records_next   = '0;
            encrypted_next = '0;
        end

        n_wr = s_fire ? ({1'b0, r0_valid} + {1'b0, s_data.end_of_message}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            skip_reg      <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            records_reg   <= '0;
            encrypted_reg <= '0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            records_reg   <= records_next;
            encrypted_reg <= encrypted_next;
        end
    end

    // queue storage: up to two beats written per cycle
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (r0_valid) begin
                q_reg[wr_ptr_reg] <= r0_beat;
                if (s_data.end_of_message) begin
                    q_reg[wr_ptr_reg + 1'b1] <= sum_beat;
                end
            end else if (s_data.end_of_message) begin
                q_reg[wr_ptr_reg] <= sum_beat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_wr);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(m_fire);
            count_reg  <= count_reg + (QPTR_W+1)'(n_wr) - (QPTR_W+1)'(m_fire);
        end
    end

endmodule

// File: hw/rtl/tlvsp_checker.sv
// Port-level checks for the TLV stream parser result channel.
// Depends on tlvsp_pkg; bound to tlv_stream_parser below.
`timescale 1ns / 1ps

module tlvsp_checker
    import tlvsp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // the summary always closes the results of its byte
    a_sum_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_SUMMARY |-> m_data.last)
        else $error("summary without last");

    // counts and status only travel in the summary
    a_rec_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_RECORD || m_data.kind == KIND_PAYLOAD)
        |-> m_data.record_count == '0 && m_data.encrypted_count == '0
            && m_data.status == STATUS_OK)
        else $error("record beat carries summary fields");

    // a truncated header zeroes the encrypted count
    a_trunc_enc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_SUMMARY && m_data.status == STATUS_HDR_TRUNC
        |-> m_data.encrypted_count == '0)
        else $error("encrypted count nonzero on truncated header");

endmodule

bind tlv_stream_parser tlvsp_checker u_tlvsp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
